// File: src/rpip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpip_pkg: shared types and constants of the radix-prefixed integer parser
// Character classes, parse phases, radix codes and the word carried from the
// classifier to the parse engine.
// ----------------------------------------------------------------------------
package rpip_pkg;

    localparam int MAX_CHARS_DEFAULT = 79;
    localparam int COUNT_W           = 7;
    localparam int VALUE_W           = 64;
    localparam int DIGIT_W           = 5;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

    // Digit value given to characters that are no digit in any radix.
    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CASE_OFS  = 8'h20;

    typedef enum logic [3:0] {
        K_NUL,
        K_DOLLAR,
        K_ZERO,
        K_AMP,
        K_X,
        K_H,
        K_O,
        K_B,
        K_D,
        K_SPACE,
        K_PLUS,
        K_MINUS,
        K_OTHER
    } kind_t;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SECOND,
        PH_LEAD,
        PH_DIGITS,
        PH_FROZEN
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC,
        RX_HEX,
        RX_OCT,
        RX_BIN
    } radix_t;

    typedef struct packed {
        kind_t               kind;
        logic [DIGIT_W-1:0]  digit;
        logic                ignore;
        logic                last;
    } cls_t;

endpackage

// File: src/rpip_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpip_front: character classifier
// Accepts one character per cycle unless the queue is full; folds case,
// decodes class and digit, marks chars past the length limit, pushes the word.
// ----------------------------------------------------------------------------
module rpip_front #(
    parameter int MAX_CHARS = rpip_pkg::MAX_CHARS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [7:0]           char_code,
    input  logic                 end_of_text,
    input  logic                 q_full,
    output logic                 q_push,
    output rpip_pkg::cls_t       q_wdata
);

    localparam logic [rpip_pkg::COUNT_W-1:0] MAX_C = rpip_pkg::COUNT_W'(MAX_CHARS);

    logic [rpip_pkg::COUNT_W-1:0] count_reg;
    logic [rpip_pkg::COUNT_W-1:0] count_next;
    logic [7:0]                   folded;

    assign item_ready = !q_full;
    assign q_push     = item_valid && item_ready;

    always_comb
    begin
        if (char_code >= rpip_pkg::CH_LOW_A && char_code <= rpip_pkg::CH_LOW_Z)
        begin
            folded = char_code - rpip_pkg::CASE_OFS;
        end
        else
        begin
            folded = char_code;
        end
    end

    always_comb
    begin
        q_wdata.last   = end_of_text;
        q_wdata.ignore = (count_reg >= MAX_C);

        if (folded >= rpip_pkg::CH_ZERO && folded <= rpip_pkg::CH_NINE)
        begin
            q_wdata.digit = rpip_pkg::DIGIT_W'(folded - rpip_pkg::CH_ZERO);
        end
        else if (folded >= rpip_pkg::CH_A && folded <= rpip_pkg::CH_F)
        begin
            q_wdata.digit = rpip_pkg::DIGIT_W'(folded - rpip_pkg::CH_A + 8'd10);
        end
        else
        begin
            q_wdata.digit = rpip_pkg::DIGIT_NONE;
        end

        if (folded == rpip_pkg::CH_NUL)
        begin
            q_wdata.kind = rpip_pkg::K_NUL;
        end
        else if (folded == rpip_pkg::CH_DOLLAR)
        begin
            q_wdata.kind = rpip_pkg::K_DOLLAR;
        end
        else if (folded == rpip_pkg::CH_ZERO)
        begin
            q_wdata.kind = rpip_pkg::K_ZERO;
        end
        else if (folded == rpip_pkg::CH_AMP)
        begin
            q_wdata.kind = rpip_pkg::K_AMP;
        end
        else if (folded == rpip_pkg::CH_X)
        begin
            q_wdata.kind = rpip_pkg::K_X;
        end
        else if (folded == rpip_pkg::CH_H)
        begin
            q_wdata.kind = rpip_pkg::K_H;
        end
        else if (folded == rpip_pkg::CH_O)
        begin
            q_wdata.kind = rpip_pkg::K_O;
        end
        else if (folded == rpip_pkg::CH_B)
        begin
            q_wdata.kind = rpip_pkg::K_B;
        end
        else if (folded == rpip_pkg::CH_D)
        begin
            q_wdata.kind = rpip_pkg::K_D;
        end
        else if (folded == rpip_pkg::CH_SPACE
                 || (folded >= rpip_pkg::CH_TAB && folded <= rpip_pkg::CH_CR))
        begin
            q_wdata.kind = rpip_pkg::K_SPACE;
        end
        else if (folded == rpip_pkg::CH_PLUS)
        begin
            q_wdata.kind = rpip_pkg::K_PLUS;
        end
        else if (folded == rpip_pkg::CH_MINUS)
        begin
            q_wdata.kind = rpip_pkg::K_MINUS;
        end
        else
        begin
            q_wdata.kind = rpip_pkg::K_OTHER;
        end
    end

    // The count restarts with every string and saturates at its full range.
    always_comb
    begin
        count_next = count_reg;
        if (q_push)
        begin
            if (end_of_text)
            begin
                count_next = '0;
            end
            else if (count_reg != '1)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// File: src/rpip_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpip_queue: short word queue
// Decouples the classifier from the parse engine so either side can stall.
// ----------------------------------------------------------------------------
module rpip_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rpip_pkg::cls_t       wdata,
    input  logic                 pop,
    output logic                 full,
    output logic                 rvalid,
    output rpip_pkg::cls_t       rdata
);

    rpip_pkg::cls_t                  mem [rpip_pkg::QUEUE_DEPTH];
    logic [rpip_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [rpip_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [rpip_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [rpip_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [rpip_pkg::QCNT_W-1:0]     cnt_reg;
    logic [rpip_pkg::QCNT_W-1:0]     cnt_next;

    localparam logic [rpip_pkg::QPTR_W-1:0] LAST_PTR =
        rpip_pkg::QPTR_W'(rpip_pkg::QUEUE_DEPTH - 1);
    localparam logic [rpip_pkg::QCNT_W-1:0] FULL_CNT =
        rpip_pkg::QCNT_W'(rpip_pkg::QUEUE_DEPTH);

    assign full   = (cnt_reg == FULL_CNT);
    assign rvalid = (cnt_reg != '0);
    assign rdata  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: src/rpip_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpip_back: parse engine
// Runs the prefix and sign state machine, accumulates digits and holds the
// finished value in an output register until it is taken.
// ----------------------------------------------------------------------------
module rpip_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  rpip_pkg::cls_t                    q_rdata,
    output logic                              q_pop,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [rpip_pkg::VALUE_W-1:0]      parsed_value
);

    rpip_pkg::phase_t               phase_reg;
    rpip_pkg::phase_t               phase_next;
    rpip_pkg::radix_t               radix_reg;
    rpip_pkg::radix_t               radix_next;
    rpip_pkg::radix_t               radix_use;
    logic [rpip_pkg::VALUE_W-1:0]   acc_reg;
    logic [rpip_pkg::VALUE_W-1:0]   acc_next;
    logic [rpip_pkg::VALUE_W-1:0]   acc_shift;
    logic                           neg_reg;
    logic                           neg_next;
    logic                           amp_reg;
    logic                           amp_next;
    logic                           res_valid_reg;
    logic                           res_valid_next;
    logic [rpip_pkg::VALUE_W-1:0]   res_acc_reg;
    logic                           res_neg_reg;
    logic                           lead_req;
    logic                           digit_req;
    logic                           digit_ok;

    // A final character may enter only when the output register is free.
    assign q_pop = q_valid && (!q_rdata.last || !res_valid_reg || result_ready);

    assign result_valid = res_valid_reg;
    assign parsed_value = res_neg_reg ? (~res_acc_reg + 1'b1) : res_acc_reg;

    always_comb
    begin
        unique case (radix_use)
            rpip_pkg::RX_HEX:
            begin
                digit_ok  = (q_rdata.digit < 5'd16);
                acc_shift = acc_reg << 4;
            end
            rpip_pkg::RX_OCT:
            begin
                digit_ok  = (q_rdata.digit < 5'd8);
                acc_shift = acc_reg << 3;
            end
            rpip_pkg::RX_BIN:
            begin
                digit_ok  = (q_rdata.digit < 5'd2);
                acc_shift = acc_reg << 1;
            end
            default:
            begin
                digit_ok  = (q_rdata.digit < 5'd10);
                acc_shift = (acc_reg << 3) + (acc_reg << 1);
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        radix_use  = radix_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        amp_next   = amp_reg;
        lead_req   = 1'b0;
        digit_req  = 1'b0;

        if (q_pop && !q_rdata.ignore && phase_reg != rpip_pkg::PH_FROZEN)
        begin
            if (q_rdata.kind == rpip_pkg::K_NUL)
            begin
                phase_next = rpip_pkg::PH_FROZEN;
            end
            else
            begin
                unique case (phase_reg)
                    rpip_pkg::PH_FIRST:
                    begin
                        if (q_rdata.kind == rpip_pkg::K_DOLLAR)
                        begin
                            radix_next = rpip_pkg::RX_HEX;
                            phase_next = rpip_pkg::PH_DIGITS;
                        end
                        else if (q_rdata.kind == rpip_pkg::K_ZERO
                                 || q_rdata.kind == rpip_pkg::K_AMP)
                        begin
                            amp_next   = (q_rdata.kind == rpip_pkg::K_AMP);
                            phase_next = rpip_pkg::PH_SECOND;
                        end
                        else
                        begin
                            radix_next = rpip_pkg::RX_DEC;
                            radix_use  = rpip_pkg::RX_DEC;
                            lead_req   = 1'b1;
                        end
                    end
                    rpip_pkg::PH_SECOND:
                    begin
                        if (amp_reg)
                        begin
                            if (q_rdata.kind == rpip_pkg::K_H)
                            begin
                                radix_next = rpip_pkg::RX_HEX;
                                phase_next = rpip_pkg::PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = rpip_pkg::PH_FROZEN;
                            end
                        end
                        else if (q_rdata.kind == rpip_pkg::K_X)
                        begin
                            radix_next = rpip_pkg::RX_HEX;
                            phase_next = rpip_pkg::PH_DIGITS;
                        end
                        else if (q_rdata.kind == rpip_pkg::K_O)
                        begin
                            radix_next = rpip_pkg::RX_OCT;
                            phase_next = rpip_pkg::PH_DIGITS;
                        end
                        else if (q_rdata.kind == rpip_pkg::K_B)
                        begin
                            radix_next = rpip_pkg::RX_BIN;
                            phase_next = rpip_pkg::PH_DIGITS;
                        end
                        else if (q_rdata.kind == rpip_pkg::K_D)
                        begin
                            radix_next = rpip_pkg::RX_DEC;
                            phase_next = rpip_pkg::PH_LEAD;
                        end
                        else
                        begin
                            // The leading zero was itself a decimal digit; the
                            // accumulator still holds zero here.
                            radix_next = rpip_pkg::RX_DEC;
                            radix_use  = rpip_pkg::RX_DEC;
                            phase_next = rpip_pkg::PH_DIGITS;
                            digit_req  = 1'b1;
                        end
                    end
                    rpip_pkg::PH_LEAD:
                    begin
                        lead_req = 1'b1;
                    end
                    rpip_pkg::PH_DIGITS:
                    begin
                        digit_req = 1'b1;
                    end
                    default:
                    begin
                        phase_next = rpip_pkg::PH_FROZEN;
                    end
                endcase
            end

            if (lead_req)
            begin
                if (q_rdata.kind == rpip_pkg::K_SPACE)
                begin
                    phase_next = rpip_pkg::PH_LEAD;
                end
                else if (q_rdata.kind == rpip_pkg::K_PLUS
                         || q_rdata.kind == rpip_pkg::K_MINUS)
                begin
                    neg_next   = (q_rdata.kind == rpip_pkg::K_MINUS);
                    phase_next = rpip_pkg::PH_DIGITS;
                end
                else
                begin
                    phase_next = rpip_pkg::PH_DIGITS;
                    digit_req  = 1'b1;
                end
            end

            if (digit_req)
            begin
                if (digit_ok)
                begin
                    acc_next = acc_shift
                               + {{(rpip_pkg::VALUE_W - rpip_pkg::DIGIT_W){1'b0}},
                                  q_rdata.digit};
                end
                else
                begin
                    phase_next = rpip_pkg::PH_FROZEN;
                end
            end
        end

        res_valid_next = (res_valid_reg && !result_ready) || (q_pop && q_rdata.last);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_rdata.last)
        begin
            res_acc_reg <= acc_next;
            res_neg_reg <= neg_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= rpip_pkg::PH_FIRST;
            radix_reg     <= rpip_pkg::RX_DEC;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            amp_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (q_pop && q_rdata.last)
            begin
                phase_reg <= rpip_pkg::PH_FIRST;
                radix_reg <= rpip_pkg::RX_DEC;
                acc_reg   <= '0;
                neg_reg   <= 1'b0;
                amp_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                radix_reg <= radix_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                amp_reg   <= amp_next;
            end
        end
    end

endmodule

// File: src/radix_prefixed_integer_parser_core.sv
// Latency: a character is stored in the word queue, then parsed into the
// state registers; a string's value shows the cycle after its last word pops.
// Throughput: one character per cycle while the queue is not full.
// Reset: asynchronous, active low; clears the queue, the parse state and the
// result valid flag. No clearing pass is needed.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_prefixed_integer_parser_core: streaming multi-radix integer parser
// Classifier, word queue and parse engine; one signed 64-bit value per string.
// ----------------------------------------------------------------------------
module radix_prefixed_integer_parser_core #(
    parameter int MAX_CHARS = rpip_pkg::MAX_CHARS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic [7:0]                        char_code,
    input  logic                              end_of_text,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [rpip_pkg::VALUE_W-1:0] parsed_value
);

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;
    rpip_pkg::cls_t     q_wdata;
    rpip_pkg::cls_t     q_rdata;
    logic [rpip_pkg::VALUE_W-1:0] value_bits;

    assign parsed_value = value_bits;

    rpip_front #(
        .MAX_CHARS (MAX_CHARS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    rpip_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .full   (q_full),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    rpip_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_rdata      (q_rdata),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .parsed_value (value_bits)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("word pushed into a full queue");

    a_pop_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("word popped from an empty queue");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(q_pop && q_rdata.last))
        else $error("result raised without a final word");
`endif

endmodule
